// ----- hdl/generational_slot_allocator_macros.svh -----
`ifndef GENERATIONAL_SLOT_ALLOCATOR_MACROS_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_MACROS_SVH

// Check that holds in the same cycle as its condition.
`define GSA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("generational_slot_allocator: same-cycle check failed");

// Check that holds in the cycle after its condition.
`define GSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("generational_slot_allocator: next-cycle check failed");

`endif

// ----- hdl/gsa_pkg.sv -----
`timescale 1ns / 1ps

package gsa_pkg;

   localparam int POOL_SLOTS_DEFAULT = 64;
   localparam int FIELD_W            = 16;
   localparam int GEN_W              = 16;

   localparam logic [FIELD_W-1:0] INVALID_INDEX = 16'hFFFF;

   typedef enum logic [1:0] {
      KIND_ACQUIRE = 2'd0,
      KIND_RELEASE = 2'd1,
      KIND_LOOKUP  = 2'd2
   } kind_type;

   typedef struct packed {
      logic ok;
      logic pop;
      logic push;
      logic slot_we;
   } exec_ctrl_type;

endpackage

// ----- hdl/gsa_ram.sv -----
`timescale 1ns / 1ps

module gsa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Write-first: a read that meets a write to the same entry sees the new data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/gsa_exec.sv -----
`timescale 1ns / 1ps

module gsa_exec import gsa_pkg::*; #(
   parameter int POOL_SLOTS = POOL_SLOTS_DEFAULT
) (
   input  kind_type                          kind,
   input  logic [FIELD_W-1:0]                slot_index,
   input  logic [GEN_W-1:0]                  handle_gen,
   input  logic [$clog2(POOL_SLOTS+1)-1:0]   top,
   input  logic [$clog2(POOL_SLOTS)-1:0]     stack_slot,
   input  logic [GEN_W-1:0]                  stack_gen,
   input  logic                              slot_active,
   input  logic [GEN_W-1:0]                  slot_gen,
   output exec_ctrl_type                     ctrl,
   output logic [FIELD_W-1:0]                out_index,
   output logic [GEN_W-1:0]                  out_gen,
   output logic [$clog2(POOL_SLOTS+1)-1:0]   top_next,
   output logic [$clog2(POOL_SLOTS)-1:0]     slot_waddr,
   output logic                              slot_wactive,
   output logic [GEN_W-1:0]                  slot_wgen,
   output logic [$clog2(POOL_SLOTS)-1:0]     stack_waddr,
   output logic [$clog2(POOL_SLOTS)-1:0]     stack_wslot,
   output logic [GEN_W-1:0]                  stack_wgen
);

   localparam int SLOT_W = $clog2(POOL_SLOTS);
   localparam int TOP_W  = $clog2(POOL_SLOTS + 1);

   logic             live;
   logic [TOP_W-1:0] top_dec;
   logic [GEN_W-1:0] gen_inc;

   assign live    = (slot_index < FIELD_W'(POOL_SLOTS)) && slot_active
                    && (slot_gen == handle_gen);
   assign top_dec = top - TOP_W'(1);
   assign gen_inc = handle_gen + GEN_W'(1);

   assign stack_waddr = top_dec[SLOT_W-1:0];
   assign stack_wslot = slot_index[SLOT_W-1:0];
   assign stack_wgen  = gen_inc;

   always_comb begin
      ctrl         = '0;
      out_index    = slot_index;
      out_gen      = handle_gen;
      top_next     = top;
      slot_waddr   = stack_slot;
      slot_wactive = 1'b0;
      slot_wgen    = stack_gen;
      unique case (kind)
         KIND_ACQUIRE: begin
            if (top < TOP_W'(POOL_SLOTS)) begin
               ctrl.ok      = 1'b1;
               ctrl.pop     = 1'b1;
               ctrl.slot_we = 1'b1;
               slot_wactive = 1'b1;
               out_index    = {{(FIELD_W-SLOT_W){1'b0}}, stack_slot};
               out_gen      = stack_gen;
               top_next     = top + TOP_W'(1);
            end else begin
               out_index = INVALID_INDEX;
               out_gen   = '0;
            end
         end
         KIND_RELEASE: begin
            if (live && (top != '0)) begin
               ctrl.ok      = 1'b1;
               ctrl.push    = 1'b1;
               ctrl.slot_we = 1'b1;
               slot_waddr   = slot_index[SLOT_W-1:0];
               slot_wgen    = gen_inc;
               top_next     = top_dec;
            end
         end
         KIND_LOOKUP: begin
            ctrl.ok = live;
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- hdl/generational_slot_allocator.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// req_      in         req_valid / req_stall     req_kind, req_slot_index, req_handle_gen
// rsp_      out        rsp_valid / rsp_stall     rsp_ok, rsp_out_index, rsp_out_gen
//
// One request per cycle while req_stall is low. On accept the request is loaded
// into the decision stage and the free stack and the slot table are read; the
// decision stage then decides, writes back and loads the result register. After
// reset a clearing pass fills the free stack and zeroes the slot table; req_stall
// stays high throughout it. A stalled result holds any request in the decision
// stage, and req_stall is high while that request waits.

`include "generational_slot_allocator_macros.svh"

module generational_slot_allocator import gsa_pkg::*; #(
   parameter int POOL_SLOTS = POOL_SLOTS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic [FIELD_W-1:0] req_slot_index,
   input  logic [GEN_W-1:0]   req_handle_gen,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_ok,
   output logic [FIELD_W-1:0] rsp_out_index,
   output logic [GEN_W-1:0]   rsp_out_gen
);

   localparam int SLOT_W = $clog2(POOL_SLOTS);
   localparam int TOP_W  = $clog2(POOL_SLOTS + 1);

   // Clearing pass
   logic              clearing_ff, clearing_in;
   logic [SLOT_W-1:0] clr_addr_ff, clr_addr_in;

   // Decision stage: request held while the memories answer
   logic               b_valid_ff, b_valid_in;
   kind_type           b_kind_ff;
   logic [FIELD_W-1:0] b_index_ff;
   logic [GEN_W-1:0]   b_gen_ff;

   // Stack pointer: count of slots handed out
   logic [TOP_W-1:0] top_ff, top_in;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff;
   logic [FIELD_W-1:0] rsp_index_ff;
   logic [GEN_W-1:0]   rsp_gen_ff;

   logic accept, advance, b_fire;

   // Memory ports
   logic                    stack_we, slot_we;
   logic [SLOT_W-1:0]       stack_waddr_mux, slot_waddr_mux;
   logic [SLOT_W+GEN_W-1:0] stack_wdata, stack_rdata;
   logic [GEN_W:0]          slot_wdata, slot_rdata;

   // Decision outputs
   exec_ctrl_type      ex_ctrl;
   logic [FIELD_W-1:0] ex_index;
   logic [GEN_W-1:0]   ex_gen;
   logic [TOP_W-1:0]   ex_top_next;
   logic [SLOT_W-1:0]  ex_slot_waddr, ex_stack_waddr, ex_stack_wslot;
   logic               ex_slot_wactive;
   logic [GEN_W-1:0]   ex_slot_wgen, ex_stack_wgen;

   // Move the result on when the output is empty or being taken; the
   // decision stage follows it, and a new request enters behind.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign b_fire    = b_valid_ff && advance;
   assign req_stall = clearing_ff || (b_valid_ff && !advance);
   assign accept    = req_valid && !req_stall;

   // Clearing pass: one entry of each memory per cycle.
   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + SLOT_W'(1);
         if (clr_addr_ff == SLOT_W'(POOL_SLOTS - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Decision stage valid: load on accept, drop once handed on.
   always_comb begin
      b_valid_in = b_valid_ff;
      if (accept) begin
         b_valid_in = 1'b1;
      end else if (advance) begin
         b_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_kind_ff  <= kind_type'(req_kind);
         b_index_ff <= req_slot_index;
         b_gen_ff   <= req_handle_gen;
      end
   end

   // Advance the stack pointer with each decided request; the next read of
   // the stack uses the updated value so back-to-back requests see it.
   assign top_in = b_fire ? ex_top_next : top_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= '0;
      end else begin
         top_ff <= top_in;
      end
   end

   // Free stack entries carry the slot and the generation it will be handed
   // out with, so an acquire needs no second lookup.
   assign stack_we        = clearing_ff || (b_fire && ex_ctrl.push);
   assign stack_waddr_mux = clearing_ff ? clr_addr_ff : ex_stack_waddr;
   assign stack_wdata     = clearing_ff ? {clr_addr_ff, GEN_W'(0)}
                                        : {ex_stack_wslot, ex_stack_wgen};

   gsa_ram #(
      .WIDTH (SLOT_W + GEN_W),
      .DEPTH (POOL_SLOTS)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (stack_waddr_mux),
      .wr_data (stack_wdata),
      .rd_en   (accept),
      .rd_addr (top_in[SLOT_W-1:0]),
      .rd_data (stack_rdata)
   );

   // Slot table: active bit over generation.
   assign slot_we        = clearing_ff || (b_fire && ex_ctrl.slot_we);
   assign slot_waddr_mux = clearing_ff ? clr_addr_ff : ex_slot_waddr;
   assign slot_wdata     = clearing_ff ? '0 : {ex_slot_wactive, ex_slot_wgen};

   gsa_ram #(
      .WIDTH (GEN_W + 1),
      .DEPTH (POOL_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr_mux),
      .wr_data (slot_wdata),
      .rd_en   (accept),
      .rd_addr (req_slot_index[SLOT_W-1:0]),
      .rd_data (slot_rdata)
   );

   gsa_exec #(
      .POOL_SLOTS (POOL_SLOTS)
   ) u_exec (
      .kind         (b_kind_ff),
      .slot_index   (b_index_ff),
      .handle_gen   (b_gen_ff),
      .top          (top_ff),
      .stack_slot   (stack_rdata[SLOT_W+GEN_W-1:GEN_W]),
      .stack_gen    (stack_rdata[GEN_W-1:0]),
      .slot_active  (slot_rdata[GEN_W]),
      .slot_gen     (slot_rdata[GEN_W-1:0]),
      .ctrl         (ex_ctrl),
      .out_index    (ex_index),
      .out_gen      (ex_gen),
      .top_next     (ex_top_next),
      .slot_waddr   (ex_slot_waddr),
      .slot_wactive (ex_slot_wactive),
      .slot_wgen    (ex_slot_wgen),
      .stack_waddr  (ex_stack_waddr),
      .stack_wslot  (ex_stack_wslot),
      .stack_wgen   (ex_stack_wgen)
   );

   // Result register: hold while stalled.
   assign rsp_valid_in = advance ? b_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_fire) begin
         rsp_ok_ff    <= ex_ctrl.ok;
         rsp_index_ff <= ex_index;
         rsp_gen_ff   <= ex_gen;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ok        = rsp_ok_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_out_gen   = rsp_gen_ff;

   // The pointer never passes the pool size.
   `GSA_ASSERT_NOW(a_top_bound, clock, reset, 1'b1, top_ff <= TOP_W'(POOL_SLOTS))
   // A successful acquire bumps the pointer by exactly one.
   `GSA_ASSERT_NEXT(a_pop_step, clock, reset, b_fire && ex_ctrl.pop, top_ff == $past(top_ff) + TOP_W'(1))
   // The clearing pass ends with an empty allocation count.
   `GSA_ASSERT_NOW(a_clear_done, clock, reset, $fell(clearing_ff), top_ff == '0 && !b_valid_ff)

endmodule
